/* sv/rcdl_pkg.sv */
package rcdl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_MAX  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_PERIOD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STROBE_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SIREN_STEP    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SIREN_LOW     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SIREN_HIGH    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SIREN_INC     = 3'd7;

   // command kinds
   localparam logic [1:0] CMD_NONE      = 2'd0;
   localparam logic [1:0] CMD_DEVIATION = 2'd1;
   localparam logic [1:0] CMD_STOP      = 2'd2;

   // pulse width thresholds and drive values in microseconds
   localparam logic [15:0] NEUTRAL_US      = 16'd1500;
   localparam logic [15:0] MODE_AUTO_US    = 16'd1500;
   localparam logic [15:0] LIGHT_ON_US     = 16'd1600;
   localparam logic [15:0] SIREN_ON_US     = 16'd1500;
   localparam logic [15:0] STEER_MIN_US    = 16'd1000;
   localparam logic [15:0] STEER_MAX_US    = 16'd2000;
   localparam logic [15:0] LEFT_TURN_US    = 16'd1450;
   localparam logic [15:0] RIGHT_TURN_US   = 16'd1550;
   localparam logic [15:0] ANGLE_FINE_MIN  = 16'd1400;
   localparam logic [15:0] ANGLE_FINE_MAX  = 16'd1600;
   localparam logic [15:0] ANGLE_HARD_L    = 16'd1000;
   localparam logic [15:0] ANGLE_HARD_R    = 16'd2000;
   localparam logic [15:0] ANGLE_WIDE_L    = 16'd1800;
   localparam logic [15:0] ANGLE_WIDE_R    = 16'd1200;
   localparam logic [15:0] SPEED_FINE      = 16'd1560;
   localparam logic [15:0] SPEED_MID       = 16'd1550;
   localparam logic [15:0] SPEED_SLOW      = 16'd1440;
   localparam logic [15:0] SPEED_CRAWL     = 16'd1430;
   localparam logic [15:0] SPEED_STOP      = 16'd1435;
   localparam logic signed [12:0] DEV_GAIN = 13'sd40;

   // reset values of the registers
   localparam logic [15:0] THROTTLE_MIN_RST  = 16'd1440;
   localparam logic [15:0] THROTTLE_MAX_RST  = 16'd1560;
   localparam logic [15:0] BLINK_PERIOD_RST  = 16'd200;
   localparam logic [15:0] STROBE_PERIOD_RST = 16'd300;
   localparam logic [7:0]  SIREN_STEP_RST    = 8'd5;
   localparam logic [11:0] SIREN_LOW_RST     = 12'd500;
   localparam logic [11:0] SIREN_HIGH_RST    = 12'd1000;
   localparam logic [7:0]  SIREN_INC_RST     = 8'd10;
   localparam logic [11:0] SWEEP_RST         = 12'd500;
   localparam logic [11:0] HZ_MAX            = 12'd4095;

   typedef struct packed {
      logic [15:0]        steer_width_in;
      logic [15:0]        throttle_width_in;
      logic [15:0]        mode_width_in;
      logic [15:0]        light_width_in;
      logic [15:0]        siren_width_in;
      logic [1:0]         command_kind;
      logic signed [15:0] deviation;
   } req_word_type;

   typedef struct packed {
      logic [15:0] esc_width_out;
      logic [15:0] servo_width_out;
      logic        left_lamp;
      logic        right_lamp;
      logic        red_lamp;
      logic        blue_lamp;
      logic        tone_on;
      logic [11:0] tone_hz;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_word_type;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
   } thr_window_type;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] angle;
   } drive_type;

endpackage

/* sv/rcdl_req_if.sv */
interface rcdl_req_if;
   import rcdl_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* sv/rcdl_rsp_if.sv */
interface rcdl_rsp_if;
   import rcdl_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* sv/rcdl_csr_if.sv */
interface rcdl_csr_if;
   import rcdl_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* sv/rcdl_drive.sv */
module rcdl_drive (
   input  rcdl_pkg::req_word_type   item,
   input  rcdl_pkg::thr_window_type window,
   input  rcdl_pkg::drive_type      held,
   output rcdl_pkg::drive_type      drive
);
   import rcdl_pkg::*;

   logic signed [15:0] dev;
   logic signed [12:0] fine_raw;
   logic [15:0]        fine_angle;
   logic [15:0]        thr_lo;
   drive_type          auto_drive;

   assign dev = item.deviation;
   // only used for |dev| < 40, so the low byte carries the value
   assign fine_raw = 13'sd1500 - 13'($signed(dev[7:0])) * DEV_GAIN;

   always_comb begin
      if (fine_raw < $signed({1'b0, ANGLE_FINE_MIN[11:0]})) begin
         fine_angle = ANGLE_FINE_MIN;
      end else if (fine_raw > $signed({1'b0, ANGLE_FINE_MAX[11:0]})) begin
         fine_angle = ANGLE_FINE_MAX;
      end else begin
         fine_angle = 16'(fine_raw);
      end
   end

   always_comb begin
      priority if (dev == 16'sd0) begin
         auto_drive = held;
      end else if (dev > -16'sd40 && dev < 16'sd40) begin
         auto_drive = '{speed: SPEED_FINE, angle: fine_angle};
      end else if (dev >= 16'sd40 && dev < 16'sd80) begin
         auto_drive = '{speed: SPEED_MID, angle: ANGLE_HARD_L};
      end else if (dev <= -16'sd40 && dev > -16'sd80) begin
         auto_drive = '{speed: SPEED_MID, angle: ANGLE_HARD_R};
      end else if (dev >= 16'sd80 && dev < 16'sd100) begin
         auto_drive = '{speed: SPEED_SLOW, angle: ANGLE_WIDE_L};
      end else if (dev <= -16'sd80 && dev > -16'sd100) begin
         auto_drive = '{speed: SPEED_SLOW, angle: ANGLE_WIDE_R};
      end else if (dev >= 16'sd100) begin
         auto_drive = '{speed: SPEED_CRAWL, angle: ANGLE_WIDE_L};
      end else begin
         auto_drive = '{speed: SPEED_CRAWL, angle: ANGLE_WIDE_R};
      end
   end

   // raise to the low limit first, then lower to the high limit
   assign thr_lo = (item.throttle_width_in < window.lo) ? window.lo : item.throttle_width_in;

   always_comb begin
      if (item.mode_width_in <= MODE_AUTO_US) begin
         drive.speed = (thr_lo > window.hi) ? window.hi : thr_lo;
         if (item.steer_width_in < STEER_MIN_US) begin
            drive.angle = STEER_MIN_US;
         end else if (item.steer_width_in > STEER_MAX_US) begin
            drive.angle = STEER_MAX_US;
         end else begin
            drive.angle = item.steer_width_in;
         end
      end else begin
         unique case (item.command_kind)
            CMD_DEVIATION: drive = auto_drive;
            CMD_STOP:      drive = '{speed: SPEED_STOP, angle: NEUTRAL_US};
            default:       drive = held;
         endcase
      end
   end

endmodule

/* sv/rc_drive_and_lamp_controller.sv */
// One word on req_ch is one millisecond tick. The block takes a word whenever req_ch.ready
// is high and returns exactly one result word per tick on rsp_ch. The tick is captured in
// an input register, then drive selection, lamp timers and the siren sweep are evaluated
// in one pass into the output register. Back-pressure on rsp_ch stalls the input register,
// so throughput is one tick per cycle while rsp_ch.ready stays high.
// Registers on csr_ch are accepted in every cycle and should be written only while idle.
module rc_drive_and_lamp_controller (
   input  logic       clock,
   input  logic       reset,
   rcdl_req_if.sink   req_ch,
   rcdl_rsp_if.source rsp_ch,
   rcdl_csr_if.sink   csr_ch
);
   import rcdl_pkg::*;

   // configuration
   logic [15:0] thr_min_ff, thr_max_ff, blink_ff, strobe_per_ff;
   logic [7:0]  siren_step_ff, siren_inc_ff;
   logic [11:0] siren_low_ff, siren_high_ff;

   // pipeline
   logic         in_valid_ff, in_valid_in;
   req_word_type in_data_ff;
   logic         out_valid_ff;
   rsp_word_type out_data_ff, out_data_in;
   logic         advance, fire;

   // state
   logic [31:0] ms_count_ff, left_time_ff, right_time_ff, strobe_time_ff, siren_time_ff;
   logic [31:0] left_time_in, right_time_in, strobe_time_in, siren_time_in;
   drive_type   held_ff, held_in;
   logic        left_on_ff, right_on_ff, phase_ff, red_on_ff, blue_on_ff, rising_ff;
   logic        left_on_in, right_on_in, phase_in, red_on_in, blue_on_in, rising_in;
   logic [11:0] sweep_ff, sweep_in, sounded_ff, sounded_in;

   thr_window_type window;
   logic           reversing, left_turn, right_turn, siren_sw;
   logic [12:0]    sweep_sum;
   logic [11:0]    sweep_up, sweep_dn;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_min_ff    <= THROTTLE_MIN_RST;
         thr_max_ff    <= THROTTLE_MAX_RST;
         blink_ff      <= BLINK_PERIOD_RST;
         strobe_per_ff <= STROBE_PERIOD_RST;
         siren_step_ff <= SIREN_STEP_RST;
         siren_low_ff  <= SIREN_LOW_RST;
         siren_high_ff <= SIREN_HIGH_RST;
         siren_inc_ff  <= SIREN_INC_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.data.index)
            REG_THROTTLE_MIN:  thr_min_ff    <= csr_ch.data.data;
            REG_THROTTLE_MAX:  thr_max_ff    <= csr_ch.data.data;
            REG_BLINK_PERIOD:  blink_ff      <= csr_ch.data.data;
            REG_STROBE_PERIOD: strobe_per_ff <= csr_ch.data.data;
            REG_SIREN_STEP:    siren_step_ff <= csr_ch.data.data[7:0];
            REG_SIREN_LOW:     siren_low_ff  <= csr_ch.data.data[11:0];
            REG_SIREN_HIGH:    siren_high_ff <= csr_ch.data.data[11:0];
            REG_SIREN_INC:     siren_inc_ff  <= csr_ch.data.data[7:0];
            default: ;
         endcase
      end
   end

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff <= req_ch.data;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign window = '{lo: thr_min_ff, hi: thr_max_ff};

   rcdl_drive u_drive (
      .item   (in_data_ff),
      .window (window),
      .held   (held_ff),
      .drive  (held_in)
   );

   // turn lamps
   assign reversing  = held_in.speed < NEUTRAL_US;
   assign left_turn  = !reversing && held_in.angle < LEFT_TURN_US;
   assign right_turn = !reversing && held_in.angle > RIGHT_TURN_US;

   always_comb begin
      left_on_in    = left_on_ff;
      right_on_in   = right_on_ff;
      left_time_in  = left_time_ff;
      right_time_in = right_time_ff;
      priority if (reversing) begin
         left_on_in  = 1'b1;
         right_on_in = 1'b1;
      end else if (left_turn) begin
         right_on_in = 1'b0;
         if (ms_count_ff - left_time_ff >= 32'(blink_ff)) begin
            left_on_in   = !left_on_ff;
            left_time_in = ms_count_ff;
         end
      end else if (right_turn) begin
         left_on_in = 1'b0;
         if (ms_count_ff - right_time_ff >= 32'(blink_ff)) begin
            right_on_in   = !right_on_ff;
            right_time_in = ms_count_ff;
         end
      end else begin
         left_on_in  = 1'b0;
         right_on_in = 1'b0;
      end
   end

   // strobe keeps its phase and timer while switched off
   always_comb begin
      phase_in       = phase_ff;
      strobe_time_in = strobe_time_ff;
      red_on_in      = red_on_ff;
      blue_on_in     = blue_on_ff;
      if (in_data_ff.light_width_in > LIGHT_ON_US) begin
         if (ms_count_ff - strobe_time_ff >= 32'(strobe_per_ff)) begin
            phase_in       = !phase_ff;
            strobe_time_in = ms_count_ff;
            red_on_in      = !phase_ff;
            blue_on_in     = phase_ff;
         end
      end else begin
         red_on_in  = 1'b0;
         blue_on_in = 1'b0;
      end
   end

   // siren sweep, saturating at both ends
   assign siren_sw  = in_data_ff.siren_width_in > SIREN_ON_US;
   assign sweep_sum = 13'(sweep_ff) + 13'(siren_inc_ff);
   assign sweep_up  = sweep_sum[12] ? HZ_MAX : sweep_sum[11:0];
   assign sweep_dn  = (sweep_ff > 12'(siren_inc_ff)) ? sweep_ff - 12'(siren_inc_ff) : 12'd0;

   always_comb begin
      sweep_in      = sweep_ff;
      rising_in     = rising_ff;
      siren_time_in = siren_time_ff;
      sounded_in    = sounded_ff;
      if (siren_sw) begin
         if (ms_count_ff - siren_time_ff >= 32'(siren_step_ff)) begin
            sounded_in    = sweep_ff;
            siren_time_in = ms_count_ff;
            if (rising_ff) begin
               sweep_in  = sweep_up;
               rising_in = !(sweep_up >= siren_high_ff);
            end else begin
               sweep_in  = sweep_dn;
               rising_in = sweep_dn <= siren_low_ff;
            end
         end
      end else begin
         sounded_in = 12'd0;
      end
   end

   always_comb begin
      out_data_in.esc_width_out   = held_in.speed;
      out_data_in.servo_width_out = held_in.angle;
      out_data_in.left_lamp       = left_on_in;
      out_data_in.right_lamp      = right_on_in;
      out_data_in.red_lamp        = red_on_in;
      out_data_in.blue_lamp       = blue_on_in;
      out_data_in.tone_on         = siren_sw && (sounded_in != 12'd0);
      out_data_in.tone_hz         = out_data_in.tone_on ? sounded_in : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         ms_count_ff    <= '0;
         held_ff        <= '{speed: NEUTRAL_US, angle: NEUTRAL_US};
         left_on_ff     <= 1'b0;
         right_on_ff    <= 1'b0;
         left_time_ff   <= '0;
         right_time_ff  <= '0;
         phase_ff       <= 1'b0;
         strobe_time_ff <= '0;
         red_on_ff      <= 1'b0;
         blue_on_ff     <= 1'b0;
         siren_time_ff  <= '0;
         sweep_ff       <= SWEEP_RST;
         rising_ff      <= 1'b1;
         sounded_ff     <= 12'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            out_valid_ff   <= 1'b1;
            ms_count_ff    <= ms_count_ff + 32'd1;
            held_ff        <= held_in;
            left_on_ff     <= left_on_in;
            right_on_ff    <= right_on_in;
            left_time_ff   <= left_time_in;
            right_time_ff  <= right_time_in;
            phase_ff       <= phase_in;
            strobe_time_ff <= strobe_time_in;
            red_on_ff      <= red_on_in;
            blue_on_ff     <= blue_on_in;
            siren_time_ff  <= siren_time_in;
            sweep_ff       <= sweep_in;
            rising_ff      <= rising_in;
            sounded_ff     <= sounded_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

   a_tone_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.tone_on == (out_data_ff.tone_hz != 12'd0)))
      else $error("tone_on disagrees with tone_hz");

   a_reverse_lamps: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.esc_width_out < NEUTRAL_US)
      |-> (out_data_ff.left_lamp && out_data_ff.right_lamp))
      else $error("reversing without both turn lamps");

   a_strobe_excl: assert property (@(posedge clock) disable iff (reset)
      !(red_on_ff && blue_on_ff))
      else $error("red and blue strobe on together");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> (out_valid_ff && ms_count_ff == $past(ms_count_ff) + 32'd1))
      else $error("processed tick gave no result");

endmodule
